>>> design/cpu8alu_pkg.sv
package cpu8alu_pkg;

    // operation codes
    localparam logic [4:0] MODE_ADD  = 5'd0;
    localparam logic [4:0] MODE_ADC  = 5'd1;
    localparam logic [4:0] MODE_SUB  = 5'd2;
    localparam logic [4:0] MODE_SBC  = 5'd3;
    localparam logic [4:0] MODE_AND  = 5'd4;
    localparam logic [4:0] MODE_XOR  = 5'd5;
    localparam logic [4:0] MODE_OR   = 5'd6;
    localparam logic [4:0] MODE_CP   = 5'd7;
    localparam logic [4:0] MODE_INC  = 5'd8;
    localparam logic [4:0] MODE_DEC  = 5'd9;
    localparam logic [4:0] MODE_RLC  = 5'd10;
    localparam logic [4:0] MODE_RRC  = 5'd11;
    localparam logic [4:0] MODE_RL   = 5'd12;
    localparam logic [4:0] MODE_RR   = 5'd13;
    localparam logic [4:0] MODE_SLA  = 5'd14;
    localparam logic [4:0] MODE_SRA  = 5'd15;
    localparam logic [4:0] MODE_SWAP = 5'd16;
    localparam logic [4:0] MODE_SRL  = 5'd17;
    localparam logic [4:0] MODE_BIT  = 5'd18;
    localparam logic [4:0] MODE_RES  = 5'd19;
    localparam logic [4:0] MODE_SET  = 5'd20;
    localparam logic [4:0] MODE_RLCA = 5'd21;
    localparam logic [4:0] MODE_RRCA = 5'd22;
    localparam logic [4:0] MODE_RLA  = 5'd23;
    localparam logic [4:0] MODE_RRA  = 5'd24;
    localparam logic [4:0] MODE_DAA  = 5'd25;
    localparam logic [4:0] MODE_CPL  = 5'd26;
    localparam logic [4:0] MODE_SCF  = 5'd27;
    localparam logic [4:0] MODE_CCF  = 5'd28;

    // decimal adjust constants
    localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
    localparam logic [7:0] DAA_HIGH_FIX   = 8'h60;
    localparam logic [7:0] DAA_LOW_FIX    = 8'h06;
    localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [4:0] mode;
        logic [7:0] accumulator;
        logic [7:0] operand;
        logic [2:0] bit_index;
        flags_t     flags;
    } alu_in_t;

    typedef struct packed {
        logic [7:0] result;
        flags_t     flags;
    } alu_out_t;

endpackage

>>> design/cpu8alu_core.sv
module cpu8alu_core (
    input  cpu8alu_pkg::alu_in_t  op,
    output cpu8alu_pkg::alu_out_t res
);

    logic [7:0] a;
    logic [7:0] b;
    logic       cin;
    logic [8:0] sum;
    logic [4:0] sum_lo;
    logic [8:0] diff;
    logic [4:0] diff_lo;
    logic [7:0] logic_and;
    logic [7:0] logic_xor;
    logic [7:0] logic_or;
    logic [7:0] shift_src;
    logic [7:0] shift_res;
    logic       shift_c;
    logic [7:0] bit_mask;
    logic       daa_hi_fix;
    logic [7:0] daa_mid;
    logic [7:0] daa_res;
    cpu8alu_pkg::flags_t fi;

    assign a  = op.accumulator;
    assign b  = op.operand;
    assign fi = op.flags;

    // carry into add and subtract only for the with-carry forms
    assign cin = ((op.mode == cpu8alu_pkg::MODE_ADC) || (op.mode == cpu8alu_pkg::MODE_SBC))
                 ? fi.c : 1'b0;

    // adder and subtractor with nibble carries
    assign sum     = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign diff    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

    assign logic_and = a & b;
    assign logic_xor = a ^ b;
    assign logic_or  = a | b;

    assign bit_mask = 8'h01 << op.bit_index;

    // rotate and shift unit, accumulator forms take the accumulator
    always_comb
    begin
        shift_src = (op.mode >= cpu8alu_pkg::MODE_RLCA) ? a : b;
        shift_res = shift_src;
        shift_c   = 1'b0;
        case (op.mode)
            cpu8alu_pkg::MODE_RLC, cpu8alu_pkg::MODE_RLCA:
            begin
                shift_res = {shift_src[6:0], shift_src[7]};
                shift_c   = shift_src[7];
            end
            cpu8alu_pkg::MODE_RRC, cpu8alu_pkg::MODE_RRCA:
            begin
                shift_res = {shift_src[0], shift_src[7:1]};
                shift_c   = shift_src[0];
            end
            cpu8alu_pkg::MODE_RL, cpu8alu_pkg::MODE_RLA:
            begin
                shift_res = {shift_src[6:0], fi.c};
                shift_c   = shift_src[7];
            end
            cpu8alu_pkg::MODE_RR, cpu8alu_pkg::MODE_RRA:
            begin
                shift_res = {fi.c, shift_src[7:1]};
                shift_c   = shift_src[0];
            end
            cpu8alu_pkg::MODE_SLA:
            begin
                shift_res = {shift_src[6:0], 1'b0};
                shift_c   = shift_src[7];
            end
            cpu8alu_pkg::MODE_SRA:
            begin
                shift_res = {shift_src[7], shift_src[7:1]};
                shift_c   = shift_src[0];
            end
            cpu8alu_pkg::MODE_SWAP:
            begin
                shift_res = {shift_src[3:0], shift_src[7:4]};
                shift_c   = 1'b0;
            end
            default:
            begin
                shift_res = {1'b0, shift_src[7:1]};
                shift_c   = shift_src[0];
            end
        endcase
    end

    // decimal adjust, high digit fix first, then low digit
    always_comb
    begin
        if (!fi.n)
        begin
            daa_hi_fix = fi.c || (a > cpu8alu_pkg::DAA_HIGH_LIMIT);
            daa_mid    = daa_hi_fix ? (a + cpu8alu_pkg::DAA_HIGH_FIX) : a;
            daa_res    = (fi.h || (daa_mid[3:0] > cpu8alu_pkg::DAA_LOW_LIMIT))
                         ? (daa_mid + cpu8alu_pkg::DAA_LOW_FIX) : daa_mid;
        end
        else
        begin
            daa_hi_fix = 1'b0;
            daa_mid    = fi.c ? (a - cpu8alu_pkg::DAA_HIGH_FIX) : a;
            daa_res    = fi.h ? (daa_mid - cpu8alu_pkg::DAA_LOW_FIX) : daa_mid;
        end
    end

    // result and flag select
    always_comb
    begin
        res.result = a;
        res.flags  = fi;
        unique case (op.mode) inside
            cpu8alu_pkg::MODE_ADD, cpu8alu_pkg::MODE_ADC:
            begin
                res.result = sum[7:0];
                res.flags  = '{z: (sum[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum[8]};
            end
            cpu8alu_pkg::MODE_SUB, cpu8alu_pkg::MODE_SBC, cpu8alu_pkg::MODE_CP:
            begin
                res.result = (op.mode == cpu8alu_pkg::MODE_CP) ? a : diff[7:0];
                res.flags  = '{z: (diff[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff[8]};
            end
            cpu8alu_pkg::MODE_AND:
            begin
                res.result = logic_and;
                res.flags  = '{z: (logic_and == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            cpu8alu_pkg::MODE_XOR:
            begin
                res.result = logic_xor;
                res.flags  = '{z: (logic_xor == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            cpu8alu_pkg::MODE_OR:
            begin
                res.result = logic_or;
                res.flags  = '{z: (logic_or == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            cpu8alu_pkg::MODE_INC:
            begin
                res.result = b + 8'd1;
                res.flags  = '{z: (b == 8'hFF), n: 1'b0, h: (b[3:0] == 4'hF), c: fi.c};
            end
            cpu8alu_pkg::MODE_DEC:
            begin
                res.result = b - 8'd1;
                res.flags  = '{z: (b == 8'h01), n: 1'b1, h: (b[3:0] == 4'h0), c: fi.c};
            end
            cpu8alu_pkg::MODE_RLC, cpu8alu_pkg::MODE_RRC, cpu8alu_pkg::MODE_RL,
            cpu8alu_pkg::MODE_RR, cpu8alu_pkg::MODE_SLA, cpu8alu_pkg::MODE_SRA,
            cpu8alu_pkg::MODE_SWAP, cpu8alu_pkg::MODE_SRL:
            begin
                res.result = shift_res;
                res.flags  = '{z: (shift_res == 8'd0), n: 1'b0, h: 1'b0, c: shift_c};
            end
            cpu8alu_pkg::MODE_RLCA, cpu8alu_pkg::MODE_RRCA, cpu8alu_pkg::MODE_RLA,
            cpu8alu_pkg::MODE_RRA:
            begin
                res.result = shift_res;
                res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: shift_c};
            end
            cpu8alu_pkg::MODE_BIT:
            begin
                res.result = b;
                res.flags  = '{z: ((b & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: fi.c};
            end
            cpu8alu_pkg::MODE_RES:
            begin
                res.result = b & ~bit_mask;
            end
            cpu8alu_pkg::MODE_SET:
            begin
                res.result = b | bit_mask;
            end
            cpu8alu_pkg::MODE_DAA:
            begin
                res.result = daa_res;
                res.flags  = '{z: (daa_res == 8'd0), n: fi.n, h: 1'b0,
                               c: (fi.c || daa_hi_fix)};
            end
            cpu8alu_pkg::MODE_CPL:
            begin
                res.result = ~a;
                res.flags  = '{z: fi.z, n: 1'b1, h: 1'b1, c: fi.c};
            end
            cpu8alu_pkg::MODE_SCF:
            begin
                res.flags  = '{z: fi.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            cpu8alu_pkg::MODE_CCF:
            begin
                res.flags  = '{z: fi.z, n: 1'b0, h: 1'b0, c: ~fi.c};
            end
            default:
            begin
                // unused codes leave accumulator and flags as they are
                res.result = a;
                res.flags  = fi;
            end
        endcase
    end

endmodule

>>> design/cpu_8bit_alu_with_flags.sv
// channel  | handshake             | beat fields
// ---------+-----------------------+------------------------------------------------
// in       | in_valid / in_stall   | mode, accumulator, operand, bit_index,
//          |                       | zero_in, subtract_in, half_carry_in, carry_in
// out      | out_valid / out_stall | result, zero_out, subtract_out,
//          |                       | half_carry_out, carry_out
//
// one beat per cycle in and out while out_stall is low; an accepted beat goes through
// the input register, one pass of the alu logic and the result register to reach out
// rst_n clears both valid flags only; the data registers are not reset
// out_stall holds the result register; in_stall rises only when both registers are full
module cpu_8bit_alu_with_flags (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] mode,
    input  logic [7:0] accumulator,
    input  logic [7:0] operand,
    input  logic [2:0] bit_index,
    input  logic       zero_in,
    input  logic       subtract_in,
    input  logic       half_carry_in,
    input  logic       carry_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result,
    output logic       zero_out,
    output logic       subtract_out,
    output logic       half_carry_out,
    output logic       carry_out
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    cpu8alu_pkg::alu_in_t  in_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    cpu8alu_pkg::alu_out_t out_reg;
    cpu8alu_pkg::alu_out_t core_res;
    logic                  out_load;
    logic                  in_load;

    // stage enables
    assign out_load       = !out_valid_reg || !out_stall;
    assign in_load        = !in_valid_reg || out_load;
    assign in_stall       = !in_load;
    assign in_valid_next  = in_load ? in_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            in_reg.mode        <= mode;
            in_reg.accumulator <= accumulator;
            in_reg.operand     <= operand;
            in_reg.bit_index   <= bit_index;
            in_reg.flags       <= '{z: zero_in, n: subtract_in, h: half_carry_in,
                                    c: carry_in};
        end
    end

    cpu8alu_core u_core (
        .op  (in_reg),
        .res (core_res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_reg <= core_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result         = out_reg.result;
    assign zero_out       = out_reg.flags.z;
    assign subtract_out   = out_reg.flags.n;
    assign half_carry_out = out_reg.flags.h;
    assign carry_out      = out_reg.flags.c;

endmodule

>>> tb/sv/cpu_8bit_alu_with_flags_test.sv
module cpu_8bit_alu_with_flags_test;
    timeunit 1ns;
    timeprecision 1ps;

    // modes with no operation behind them
    localparam logic [4:0] MODE_UNDEF_FIRST = 5'd29;
    localparam logic [4:0] MODE_UNDEF_LAST  = 5'd31;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BEATS = 450;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 60;

    // alu result predictor and queue of outstanding results
    class alu_scoreboard;
        cpu8alu_pkg::alu_out_t expected_q[$];
        int unsigned           errors = 0;

        function cpu8alu_pkg::alu_out_t predict_alu(cpu8alu_pkg::alu_in_t x);
            cpu8alu_pkg::alu_out_t y;
            logic [8:0] wide;
            logic [4:0] low_nib;
            logic [7:0] v;
            logic [7:0] r;
            logic       cin;
            logic       carry;
            logic       is_shift;
            // unknown modes pass accumulator and flags through
            y.result = x.accumulator;
            y.flags  = x.flags;
            is_shift = 1'b0;
            carry    = 1'b0;
            r        = 8'h00;
            v        = (x.mode >= cpu8alu_pkg::MODE_RLCA) ? x.accumulator : x.operand;
            case (x.mode)
                cpu8alu_pkg::MODE_ADD, cpu8alu_pkg::MODE_ADC:
                begin
                    cin      = (x.mode == cpu8alu_pkg::MODE_ADC) ? x.flags.c : 1'b0;
                    wide     = {1'b0, x.accumulator} + {1'b0, x.operand} + {8'd0, cin};
                    low_nib  = {1'b0, x.accumulator[3:0]} + {1'b0, x.operand[3:0]}
                               + {4'd0, cin};
                    y.result = wide[7:0];
                    y.flags  = {(wide[7:0] == 8'h00), 1'b0, low_nib[4], wide[8]};
                end
                cpu8alu_pkg::MODE_SUB, cpu8alu_pkg::MODE_SBC, cpu8alu_pkg::MODE_CP:
                begin
                    // bit above the top is the borrow
                    cin      = (x.mode == cpu8alu_pkg::MODE_SBC) ? x.flags.c : 1'b0;
                    wide     = {1'b0, x.accumulator} - {1'b0, x.operand} - {8'd0, cin};
                    low_nib  = {1'b0, x.accumulator[3:0]} - {1'b0, x.operand[3:0]}
                               - {4'd0, cin};
                    y.result = (x.mode == cpu8alu_pkg::MODE_CP) ? x.accumulator : wide[7:0];
                    y.flags  = {(wide[7:0] == 8'h00), 1'b1, low_nib[4], wide[8]};
                end
                cpu8alu_pkg::MODE_AND:
                begin
                    y.result = x.accumulator & x.operand;
                    y.flags  = {(y.result == 8'h00), 1'b0, 1'b1, 1'b0};
                end
                cpu8alu_pkg::MODE_XOR, cpu8alu_pkg::MODE_OR:
                begin
                    y.result = (x.mode == cpu8alu_pkg::MODE_XOR)
                               ? x.accumulator ^ x.operand
                               : x.accumulator | x.operand;
                    y.flags  = {(y.result == 8'h00), 1'b0, 1'b0, 1'b0};
                end
                cpu8alu_pkg::MODE_INC:
                begin
                    y.result = x.operand + 8'h01;
                    y.flags  = {(y.result == 8'h00), 1'b0, (x.operand[3:0] == 4'hF), x.flags.c};
                end
                cpu8alu_pkg::MODE_DEC:
                begin
                    y.result = x.operand - 8'h01;
                    y.flags  = {(y.result == 8'h00), 1'b1, (x.operand[3:0] == 4'h0), x.flags.c};
                end
                cpu8alu_pkg::MODE_RLC, cpu8alu_pkg::MODE_RLCA:
                begin
                    is_shift = 1'b1;
                    carry    = v[7];
                    r        = {v[6:0], v[7]};
                end
                cpu8alu_pkg::MODE_RRC, cpu8alu_pkg::MODE_RRCA:
                begin
                    is_shift = 1'b1;
                    carry    = v[0];
                    r        = {v[0], v[7:1]};
                end
                cpu8alu_pkg::MODE_RL, cpu8alu_pkg::MODE_RLA:
                begin
                    is_shift = 1'b1;
                    carry    = v[7];
                    r        = {v[6:0], x.flags.c};
                end
                cpu8alu_pkg::MODE_RR, cpu8alu_pkg::MODE_RRA:
                begin
                    is_shift = 1'b1;
                    carry    = v[0];
                    r        = {x.flags.c, v[7:1]};
                end
                cpu8alu_pkg::MODE_SLA:
                begin
                    is_shift = 1'b1;
                    carry    = v[7];
                    r        = {v[6:0], 1'b0};
                end
                cpu8alu_pkg::MODE_SRA:
                begin
                    is_shift = 1'b1;
                    carry    = v[0];
                    r        = {v[7], v[7:1]};
                end
                cpu8alu_pkg::MODE_SWAP:
                begin
                    is_shift = 1'b1;
                    carry    = 1'b0;
                    r        = {v[3:0], v[7:4]};
                end
                cpu8alu_pkg::MODE_SRL:
                begin
                    is_shift = 1'b1;
                    carry    = v[0];
                    r        = {1'b0, v[7:1]};
                end
                cpu8alu_pkg::MODE_BIT:
                begin
                    y.result = x.operand;
                    y.flags  = {~x.operand[x.bit_index], 1'b0, 1'b1, x.flags.c};
                end
                cpu8alu_pkg::MODE_RES:
                    y.result = x.operand & ~(8'h01 << x.bit_index);
                cpu8alu_pkg::MODE_SET:
                    y.result = x.operand | (8'h01 << x.bit_index);
                cpu8alu_pkg::MODE_DAA:
                begin
                    r     = x.accumulator;
                    carry = x.flags.c;
                    if (!x.flags.n)
                    begin
                        if (x.flags.c || r > cpu8alu_pkg::DAA_HIGH_LIMIT)
                        begin
                            r     = r + cpu8alu_pkg::DAA_HIGH_FIX;
                            carry = 1'b1;
                        end
                        if (x.flags.h || r[3:0] > cpu8alu_pkg::DAA_LOW_LIMIT)
                            r = r + cpu8alu_pkg::DAA_LOW_FIX;
                    end
                    else
                    begin
                        if (x.flags.c)
                            r = r - cpu8alu_pkg::DAA_HIGH_FIX;
                        if (x.flags.h)
                            r = r - cpu8alu_pkg::DAA_LOW_FIX;
                    end
                    y.result = r;
                    y.flags  = {(r == 8'h00), x.flags.n, 1'b0, carry};
                end
                cpu8alu_pkg::MODE_CPL:
                begin
                    y.result = ~x.accumulator;
                    y.flags  = {x.flags.z, 1'b1, 1'b1, x.flags.c};
                end
                cpu8alu_pkg::MODE_SCF:
                    y.flags = {x.flags.z, 1'b0, 1'b0, 1'b1};
                cpu8alu_pkg::MODE_CCF:
                    y.flags = {x.flags.z, 1'b0, 1'b0, ~x.flags.c};
                default:
                    y.result = x.accumulator;
            endcase
            // accumulator rotates never set the zero flag
            if (is_shift)
            begin
                y.result = r;
                y.flags  = {(x.mode >= cpu8alu_pkg::MODE_RLCA) ? 1'b0 : (r == 8'h00),
                            1'b0, 1'b0, carry};
            end
            return y;
        endfunction

        function void note_input(cpu8alu_pkg::alu_in_t x);
            expected_q.push_back(predict_alu(x));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(cpu8alu_pkg::alu_out_t got);
            cpu8alu_pkg::alu_out_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %02h", $time, got.result);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("result", want.result, got.result);
            compare_field("zero_out", {7'd0, want.flags.z}, {7'd0, got.flags.z});
            compare_field("subtract_out", {7'd0, want.flags.n}, {7'd0, got.flags.n});
            compare_field("half_carry_out", {7'd0, want.flags.h}, {7'd0, got.flags.h});
            compare_field("carry_out", {7'd0, want.flags.c}, {7'd0, got.flags.c});
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [4:0] mode = cpu8alu_pkg::MODE_ADD;
    logic [7:0] accumulator = 8'h00;
    logic [7:0] operand = 8'h00;
    logic [2:0] bit_index = 3'd0;
    logic       zero_in = 1'b0;
    logic       subtract_in = 1'b0;
    logic       half_carry_in = 1'b0;
    logic       carry_in = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] result;
    logic       zero_out;
    logic       subtract_out;
    logic       half_carry_out;
    logic       carry_out;

    alu_scoreboard alu_sb = new();
    int unsigned   cycle_count = 0;
    int unsigned   burst_left = 0;
    bit            hold_req = 1'b0;
    bit            hold_done = 1'b0;

    cpu_8bit_alu_with_flags i_dut (.*);

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // reset held low from the start, released once
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cpu_8bit_alu_with_flags_test: FAIL");
        $finish;
    end

    // beat monitor on both channels, results checked ahead of new inputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                alu_sb.check_result({result, zero_out, subtract_out, half_carry_out, carry_out});
            if (in_valid && !in_stall)
                alu_sb.note_input({mode, accumulator, operand, bit_index,
                                   zero_in, subtract_in, half_carry_in, carry_in});
        end
    end

    // output stall: segments of differing density, plus one long hold-off
    initial
    begin
        int unsigned seg_left;
        int unsigned seg_kind;
        seg_left = 0;
        seg_kind = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                seg_kind = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;
            case (seg_kind)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= seg_left[0];
            endcase
        end
    end

    // present one input beat and hold it until accepted
    task automatic send_beat(input cpu8alu_pkg::alu_in_t beat);
        in_valid      <= 1'b1;
        mode          <= beat.mode;
        accumulator   <= beat.accumulator;
        operand       <= beat.operand;
        bit_index     <= beat.bit_index;
        zero_in       <= beat.flags.z;
        subtract_in   <= beat.flags.n;
        half_carry_in <= beat.flags.h;
        carry_in      <= beat.flags.c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_op(input logic [4:0] op, input logic [7:0] acc, input logic [7:0] opd,
                           input logic [2:0] idx, input logic [3:0] flags);
        send_beat({op, acc, opd, idx, flags});
    endtask

    // send a beat, then a random gap once the current burst runs out
    task automatic send_in_bursts(input cpu8alu_pkg::alu_in_t beat);
        int unsigned gap;
        send_beat(beat);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop offering beats until every outstanding result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (alu_sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        logic [7:0] corner[8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h01, 8'h99};
        if ($urandom_range(0, 3) == 0)
            return corner[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    // stimulus
    initial
    begin
        cpu8alu_pkg::alu_in_t  beat;
        cpu8alu_pkg::alu_out_t sum;
        int unsigned           sent;
        wait (rst_n);
        @(posedge clk);

        // directed: every mode with corner operands
        send_op(cpu8alu_pkg::MODE_ADD,  8'hFF, 8'h01, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_ADC,  8'h0F, 8'h00, 3'd0, 4'b0001);
        send_op(cpu8alu_pkg::MODE_SUB,  8'h00, 8'h01, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_SBC,  8'h10, 8'h0F, 3'd0, 4'b0001);
        send_op(cpu8alu_pkg::MODE_AND,  8'hF0, 8'h0F, 3'd0, 4'b1111);
        send_op(cpu8alu_pkg::MODE_XOR,  8'hFF, 8'hFF, 3'd0, 4'b1111);
        send_op(cpu8alu_pkg::MODE_OR,   8'h00, 8'h00, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_CP,   8'h55, 8'h55, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_INC,  8'h00, 8'hFF, 3'd0, 4'b0001);
        send_op(cpu8alu_pkg::MODE_DEC,  8'h00, 8'h00, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_RLC,  8'h00, 8'h80, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_RRC,  8'h00, 8'h01, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_RL,   8'h00, 8'h80, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_RR,   8'h00, 8'h01, 3'd0, 4'b0001);
        send_op(cpu8alu_pkg::MODE_SLA,  8'h00, 8'h80, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_SRA,  8'h00, 8'h81, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_SWAP, 8'h00, 8'hF0, 3'd0, 4'b0001);
        send_op(cpu8alu_pkg::MODE_SRL,  8'h00, 8'h01, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_BIT,  8'h00, 8'h7F, 3'd7, 4'b0001);
        send_op(cpu8alu_pkg::MODE_RES,  8'h00, 8'hFF, 3'd0, 4'b1111);
        send_op(cpu8alu_pkg::MODE_SET,  8'h00, 8'h00, 3'd7, 4'b0000);
        send_op(cpu8alu_pkg::MODE_RLCA, 8'h80, 8'h00, 3'd0, 4'b1000);
        send_op(cpu8alu_pkg::MODE_RRCA, 8'h00, 8'hFF, 3'd0, 4'b1000);
        send_op(cpu8alu_pkg::MODE_RLA,  8'h80, 8'h00, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_RRA,  8'h01, 8'h00, 3'd0, 4'b0001);
        send_op(cpu8alu_pkg::MODE_DAA,  8'h9A, 8'h00, 3'd0, 4'b0000);
        send_op(cpu8alu_pkg::MODE_DAA,  8'h00, 8'h00, 3'd0, 4'b0111);
        send_op(cpu8alu_pkg::MODE_CPL,  8'h00, 8'h00, 3'd0, 4'b1000);
        send_op(cpu8alu_pkg::MODE_SCF,  8'hA5, 8'h00, 3'd0, 4'b1110);
        send_op(cpu8alu_pkg::MODE_CCF,  8'h5A, 8'h00, 3'd0, 4'b0001);
        send_op(MODE_UNDEF_FIRST, 8'hFF, 8'h00, 3'd0, 4'b1111);
        send_op(MODE_UNDEF_LAST,  8'h00, 8'hFF, 3'd7, 4'b0000);

        // pause until the pipeline has emptied
        wait_drained();

        // random beats in bursts, with bcd add or subtract then decimal adjust pairs
        sent = 0;
        burst_left = $urandom_range(1, 24);
        while (sent < RANDOM_BEATS)
        begin
            if (sent >= 120 && !hold_req)
            begin
                // keep offering beats with no gaps while the output is held off
                hold_req = 1'b1;
                burst_left = 40;
            end
            if (sent >= 300 && sent < 302)
                wait_drained();
            if ($urandom_range(0, 5) == 0)
            begin
                beat.mode        = 5'($urandom_range(cpu8alu_pkg::MODE_ADD,
                                                     cpu8alu_pkg::MODE_SBC));
                beat.accumulator = random_bcd();
                beat.operand     = random_bcd();
                beat.bit_index   = 3'($urandom_range(0, 7));
                beat.flags       = 4'($urandom_range(0, 15));
                send_in_bursts(beat);
                sum = alu_sb.predict_alu(beat);
                beat.mode        = cpu8alu_pkg::MODE_DAA;
                beat.accumulator = sum.result;
                beat.operand     = random_byte();
                beat.flags       = sum.flags;
                send_in_bursts(beat);
                sent += 2;
            end
            else
            begin
                beat.mode        = 5'($urandom_range(0, 31));
                beat.accumulator = random_byte();
                beat.operand     = random_byte();
                beat.bit_index   = 3'($urandom_range(0, 7));
                beat.flags       = 4'($urandom_range(0, 15));
                send_in_bursts(beat);
                sent++;
            end
        end

        // wait for the last results, then DRAIN_CYCLES quiet cycles
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (alu_sb.errors == 0)
            $display("cpu_8bit_alu_with_flags_test: PASS");
        else
            $display("cpu_8bit_alu_with_flags_test: FAIL");
        $finish;
    end

endmodule
